[hw/rtl/safp_pkg.sv]
// Shared types, codes and constants of the segment allocator.
`default_nettype none

package safp_pkg;

    // Default sizing
    localparam int MAX_SEGMENTS = 64;
    localparam int SIZE_BITS    = 24;
    localparam int OWNER_BITS   = 16;

    // Size the table holds after reset
    localparam logic [23:0] TOTAL_RESET = 24'hFFFFFF;

    // Request kinds
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_COMPACT = 2'd2;
    localparam logic [1:0] REQ_IGNORED = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Fit policies
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_NONE  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 1'b1;
    localparam int CFG_DATA_W = 24;

    // Request item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] owner_id;
        logic [23:0] req_size;
    } safp_req_t;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] used_total;
        logic [23:0] free_total;
        logic [23:0] largest_free;
        logic [31:0] alloc_count;
        logic [6:0]  segments_in_use;
    } safp_rsp_t;

    // Operation applied to all cells of the row in the same cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROTATE,
        OP_SQUEEZE,
        OP_INSERT,
        OP_WRITE,
        OP_INIT
    } safp_op_t;

    typedef struct packed {
        safp_op_t op;
        logic     split;
    } safp_ctrl_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MODIFY,
        S_SWEEP,
        S_SQUEEZE,
        S_APPEND,
        S_STATS,
        S_EMIT
    } safp_state_t;

endpackage

`default_nettype wire

[hw/rtl/segment_allocator_fit_policy.sv]
// Segment allocator top level: request controller around the cell row.
//
// Channels: req (valid/ready) carries one request item; rsp (valid/ready)
// returns one result item per request; cfg (valid/ready) writes register 0
// (fit policy) or register 1 (total size, which also rebuilds the table as
// one free segment). req and cfg are ready only while no request is in work.
// The table lives in a row of MAX_SEGMENTS cells; each pass rotates the row
// one slot per cycle past the controller. Steps per request, in order:
//   alloc:   scan pass, update, statistics pass, result
//   free:    sweep pass, hole squeeze, statistics pass, result
//   compact: as free, with an append step before the statistics pass
//   other:   statistics pass, result
// One request is worked on at a time. The result sits in an output register;
// if the receiver stalls, a finished request waits there and the next one
// cannot complete until the register is taken. Reset gives one free segment
// of 16777215 units, policy first fit and a zero allocation count; no
// clearing pass is needed.
`default_nettype none

module segment_allocator_fit_policy #(
    parameter int MAX_SEGMENTS = safp_pkg::MAX_SEGMENTS,
    parameter int SIZE_BITS    = safp_pkg::SIZE_BITS,
    parameter int OWNER_BITS   = safp_pkg::OWNER_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire safp_pkg::safp_req_t               req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output safp_pkg::safp_rsp_t                    rsp,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [safp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [safp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int ACC_W = SIZE_BITS + CNT_W;
    localparam logic [SIZE_BITS-1:0] RST_SIZE  = SIZE_BITS'(safp_pkg::TOTAL_RESET);
    localparam logic [CNT_W-1:0]     LAST_STEP = CNT_W'(MAX_SEGMENTS);
    localparam logic [CNT_W-1:0]     TOP_IDX   = CNT_W'(MAX_SEGMENTS - 1);

    safp_pkg::safp_state_t state_reg, state_next;

    logic [CNT_W-1:0]      t_reg, t_next;
    logic [1:0]            kind_reg, kind_next;
    logic [OWNER_BITS-1:0] owner_reg, owner_next;
    logic [SIZE_BITS-1:0]  want_reg, want_next;
    logic [1:0]            policy_reg, policy_next;
    logic [SIZE_BITS-1:0]  total_reg, total_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic [SIZE_BITS-1:0]  pick_size_reg, pick_size_next;
    logic [SIZE_BITS-1:0]  best_reg, best_next;
    logic [1:0]            status_reg, status_next;
    logic [31:0]           succ_reg, succ_next;
    logic [CNT_W-1:0]      seg_count_reg, seg_count_next;
    logic [CNT_W-1:0]      keep_reg, keep_next;
    logic [SIZE_BITS-1:0]  gather_reg, gather_next;
    logic [ACC_W-1:0]      used_acc_reg, used_acc_next;
    logic [ACC_W-1:0]      free_acc_reg, free_acc_next;
    logic [SIZE_BITS-1:0]  big_reg, big_next;
    logic [CNT_W-1:0]      cnt_acc_reg, cnt_acc_next;
    logic                  pend_v_reg, pend_v_next;
    logic                  pend_u_reg, pend_u_next;
    logic [SIZE_BITS-1:0]  pend_sz_reg, pend_sz_next;
    logic [OWNER_BITS-1:0] pend_ow_reg, pend_ow_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    safp_pkg::safp_rsp_t   rsp_reg, rsp_next;

    safp_pkg::safp_ctrl_t  ctrl;
    logic [IDX_W-1:0]      p;
    logic                  w_used;
    logic [SIZE_BITS-1:0]  w_size;
    logic [OWNER_BITS-1:0] w_owner;
    logic [SIZE_BITS-1:0]  r_size;
    logic                  head_v, head_u;
    logic [SIZE_BITS-1:0]  head_sz;
    logic [OWNER_BITS-1:0] head_ow;
    logic                  tail_v, tail_u;
    logic [SIZE_BITS-1:0]  tail_sz;
    logic [OWNER_BITS-1:0] tail_ow;
    logic                  need_squeeze;

    logic                  req_acc, cfg_acc, in_pass, last_step, split, full, emit_go;
    logic                  x_v, x_u, merge;
    logic [IDX_W-1:0]      scan_idx;

    assign req_ready = (state_reg == safp_pkg::S_IDLE);
    assign cfg_ready = (state_reg == safp_pkg::S_IDLE);
    assign req_acc   = req_valid && req_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_pass   = (state_reg == safp_pkg::S_SCAN) || (state_reg == safp_pkg::S_SWEEP)
                       || (state_reg == safp_pkg::S_STATS);
    assign last_step = (t_reg == LAST_STEP);
    assign split     = (pick_size_reg != want_reg);
    assign full      = (seg_count_reg == CNT_W'(MAX_SEGMENTS));
    assign emit_go   = !rsp_valid_reg || rsp_ready;
    assign scan_idx  = IDX_W'(TOP_IDX - t_reg);

    // Cell row
    safp_chain #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SIZE_W       (SIZE_BITS),
        .OWN_W        (OWNER_BITS),
        .IDX_W        (IDX_W),
        .RST_SIZE     (RST_SIZE)
    ) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .p            (p),
        .w_used       (w_used),
        .w_size       (w_size),
        .w_owner      (w_owner),
        .r_size       (r_size),
        .head_v       (head_v),
        .head_u       (head_u),
        .head_sz      (head_sz),
        .head_ow      (head_ow),
        .tail_v       (tail_v),
        .tail_u       (tail_u),
        .tail_sz      (tail_sz),
        .tail_ow      (tail_ow),
        .need_squeeze (need_squeeze)
    );

    // Entry leaving the tail: release by owner, or drop free space on compact
    always_comb
    begin
        x_v = tail_v;
        x_u = tail_u;
        if (state_reg == safp_pkg::S_SWEEP)
        begin
            if (kind_reg == safp_pkg::REQ_FREE && tail_v && tail_u && tail_ow == owner_reg)
            begin
                x_u = 1'b0;
            end
            if (kind_reg == safp_pkg::REQ_COMPACT && tail_v && !tail_u)
            begin
                x_v = 1'b0;
            end
        end
        merge = (state_reg == safp_pkg::S_SWEEP) && (kind_reg == safp_pkg::REQ_FREE)
                && pend_v_reg && !pend_u_reg && x_v && !x_u;
        head_v  = merge ? 1'b0 : pend_v_reg;
        head_u  = pend_u_reg;
        head_sz = pend_sz_reg;
        head_ow = pend_ow_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            safp_pkg::S_IDLE:
            begin
                if (req_acc)
                begin
                    priority if (req.req_type == safp_pkg::REQ_ALLOC)
                        state_next = safp_pkg::S_SCAN;
                    else if (req.req_type == safp_pkg::REQ_FREE
                             || req.req_type == safp_pkg::REQ_COMPACT)
                        state_next = safp_pkg::S_SWEEP;
                    else
                        state_next = safp_pkg::S_STATS;
                end
            end
            safp_pkg::S_SCAN:
            begin
                if (last_step)
                    state_next = safp_pkg::S_MODIFY;
            end
            safp_pkg::S_MODIFY:
            begin
                state_next = safp_pkg::S_STATS;
            end
            safp_pkg::S_SWEEP:
            begin
                if (last_step)
                    state_next = safp_pkg::S_SQUEEZE;
            end
            safp_pkg::S_SQUEEZE:
            begin
                if (!need_squeeze)
                    state_next = (kind_reg == safp_pkg::REQ_COMPACT) ? safp_pkg::S_APPEND
                                                                     : safp_pkg::S_STATS;
            end
            safp_pkg::S_APPEND:
            begin
                state_next = safp_pkg::S_STATS;
            end
            safp_pkg::S_STATS:
            begin
                if (last_step)
                    state_next = safp_pkg::S_EMIT;
            end
            safp_pkg::S_EMIT:
            begin
                if (emit_go)
                    state_next = safp_pkg::S_IDLE;
            end
            default:
            begin
                state_next = safp_pkg::S_IDLE;
            end
        endcase
    end

    // Cell row commands
    always_comb
    begin
        ctrl.op    = safp_pkg::OP_HOLD;
        ctrl.split = split;
        p          = '0;
        w_used     = 1'b0;
        w_size     = '0;
        w_owner    = owner_reg;
        r_size     = pick_size_reg - want_reg;
        unique case (state_reg)
            safp_pkg::S_IDLE:
            begin
                if (cfg_acc && cfg_index == safp_pkg::CFG_TOTAL)
                begin
                    ctrl.op = safp_pkg::OP_INIT;
                    w_size  = SIZE_BITS'(cfg_data);
                end
            end
            safp_pkg::S_SCAN, safp_pkg::S_SWEEP, safp_pkg::S_STATS:
            begin
                ctrl.op = safp_pkg::OP_ROTATE;
            end
            safp_pkg::S_MODIFY:
            begin
                if (found_reg && !(split && full))
                begin
                    ctrl.op = safp_pkg::OP_INSERT;
                    p       = pick_reg;
                    w_used  = 1'b1;
                    w_size  = want_reg;
                end
            end
            safp_pkg::S_SQUEEZE:
            begin
                if (need_squeeze)
                    ctrl.op = safp_pkg::OP_SQUEEZE;
            end
            safp_pkg::S_APPEND:
            begin
                if (keep_reg == '0)
                begin
                    ctrl.op = safp_pkg::OP_WRITE;
                    w_size  = (gather_reg != '0) ? gather_reg : total_reg;
                end
                else if (gather_reg != '0)
                begin
                    ctrl.op = safp_pkg::OP_WRITE;
                    p       = IDX_W'(keep_reg);
                    w_size  = gather_reg;
                end
            end
            safp_pkg::S_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        t_next         = (in_pass && !last_step) ? t_reg + CNT_W'(1) : '0;
        kind_next      = kind_reg;
        owner_next     = owner_reg;
        want_next      = want_reg;
        policy_next    = policy_reg;
        total_next     = total_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_size_next = pick_size_reg;
        best_next      = best_reg;
        status_next    = status_reg;
        succ_next      = succ_reg;
        seg_count_next = seg_count_reg;
        keep_next      = keep_reg;
        gather_next    = gather_reg;
        used_acc_next  = used_acc_reg;
        free_acc_next  = free_acc_reg;
        big_next       = big_reg;
        cnt_acc_next   = cnt_acc_reg;
        pend_v_next    = pend_v_reg;
        pend_u_next    = pend_u_reg;
        pend_sz_next   = pend_sz_reg;
        pend_ow_next   = pend_ow_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        // Request capture and register writes
        if (req_acc)
        begin
            kind_next     = req.req_type;
            owner_next    = OWNER_BITS'(req.owner_id);
            want_next     = SIZE_BITS'(req.req_size);
            found_next    = 1'b0;
            best_next     = '0;
            status_next   = safp_pkg::STAT_DONE;
            keep_next     = '0;
            gather_next   = '0;
            used_acc_next = '0;
            free_acc_next = '0;
            big_next      = '0;
            cnt_acc_next  = '0;
            pend_v_next   = 1'b0;
        end
        if (cfg_acc)
        begin
            if (cfg_index == safp_pkg::CFG_POLICY)
            begin
                policy_next = cfg_data[1:0];
            end
            else
            begin
                total_next     = SIZE_BITS'(cfg_data);
                seg_count_next = CNT_W'(1);
            end
        end

        // Pass through the pending stage
        if (in_pass)
        begin
            if (merge)
            begin
                pend_sz_next = pend_sz_reg + tail_sz;
            end
            else
            begin
                pend_v_next  = x_v;
                pend_u_next  = x_u;
                pend_sz_next = tail_sz;
                pend_ow_next = tail_ow;
            end
        end

        // Fit search, entries arrive highest index first
        if (state_reg == safp_pkg::S_SCAN && !last_step && tail_v && !tail_u
            && tail_sz >= want_reg)
        begin
            priority if (policy_reg == safp_pkg::POL_FIRST)
            begin
                found_next     = 1'b1;
                pick_next      = scan_idx;
                pick_size_next = tail_sz;
            end
            else if (policy_reg == safp_pkg::POL_BEST)
            begin
                if (!found_reg || (tail_sz - want_reg) <= best_reg)
                begin
                    found_next     = 1'b1;
                    pick_next      = scan_idx;
                    pick_size_next = tail_sz;
                    best_next      = tail_sz - want_reg;
                end
            end
            else if (policy_reg == safp_pkg::POL_WORST)
            begin
                if (tail_sz != '0 && (!found_reg || tail_sz >= best_reg))
                begin
                    found_next     = 1'b1;
                    pick_next      = scan_idx;
                    pick_size_next = tail_sz;
                    best_next      = tail_sz;
                end
            end
            else
            begin
            end
        end

        // Alloc outcome
        if (state_reg == safp_pkg::S_MODIFY)
        begin
            priority if (!found_reg)
                status_next = safp_pkg::STAT_NOFIT;
            else if (split && full)
                status_next = safp_pkg::STAT_FULL;
            else
            begin
                status_next = safp_pkg::STAT_DONE;
                if (succ_reg != '1)
                    succ_next = succ_reg + 32'd1;
            end
        end

        // Compact bookkeeping
        if (state_reg == safp_pkg::S_SWEEP && kind_reg == safp_pkg::REQ_COMPACT && tail_v)
        begin
            if (tail_u)
                keep_next = keep_reg + CNT_W'(1);
            else
                gather_next = gather_reg + tail_sz;
        end

        // Usage figures
        if (state_reg == safp_pkg::S_STATS)
        begin
            if (tail_v)
            begin
                cnt_acc_next = cnt_acc_reg + CNT_W'(1);
                if (tail_u)
                begin
                    used_acc_next = used_acc_reg + ACC_W'(tail_sz);
                end
                else
                begin
                    free_acc_next = free_acc_reg + ACC_W'(tail_sz);
                    if (tail_sz > big_reg)
                        big_next = tail_sz;
                end
            end
            if (last_step)
                seg_count_next = cnt_acc_reg;
        end

        // Result register
        if (state_reg == safp_pkg::S_EMIT && emit_go)
        begin
            rsp_valid_next           = 1'b1;
            rsp_next.status          = status_reg;
            rsp_next.used_total      = 24'(used_acc_reg);
            rsp_next.free_total      = 24'(free_acc_reg);
            rsp_next.largest_free    = 24'(big_reg);
            rsp_next.alloc_count     = succ_reg;
            rsp_next.segments_in_use = 7'(seg_count_reg);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= safp_pkg::S_IDLE;
            t_reg         <= '0;
            policy_reg    <= safp_pkg::POL_FIRST;
            total_reg     <= RST_SIZE;
            succ_reg      <= '0;
            seg_count_reg <= CNT_W'(1);
            found_reg     <= 1'b0;
            pend_v_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            kind_reg      <= safp_pkg::REQ_ALLOC;
            status_reg    <= safp_pkg::STAT_DONE;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            policy_reg    <= policy_next;
            total_reg     <= total_next;
            succ_reg      <= succ_next;
            seg_count_reg <= seg_count_next;
            found_reg     <= found_next;
            pend_v_reg    <= pend_v_next;
            rsp_valid_reg <= rsp_valid_next;
            kind_reg      <= kind_next;
            status_reg    <= status_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        owner_reg     <= owner_next;
        want_reg      <= want_next;
        pick_reg      <= pick_next;
        pick_size_reg <= pick_size_next;
        best_reg      <= best_next;
        keep_reg      <= keep_next;
        gather_reg    <= gather_next;
        used_acc_reg  <= used_acc_next;
        free_acc_reg  <= free_acc_next;
        big_reg       <= big_next;
        cnt_acc_reg   <= cnt_acc_next;
        pend_u_reg    <= pend_u_next;
        pend_sz_reg   <= pend_sz_next;
        pend_ow_reg   <= pend_ow_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_rsp_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == safp_pkg::S_EMIT))
        else $error("result raised outside the emit state");

    a_init_one_seg: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_acc && cfg_index == safp_pkg::CFG_TOTAL) |=> seg_count_reg == CNT_W'(1))
        else $error("table rebuild did not leave one segment");

    a_succ_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> succ_reg >= $past(succ_reg))
        else $error("allocation count went down");

    a_nofit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == safp_pkg::S_MODIFY && !found_reg) |=>
            status_reg == safp_pkg::STAT_NOFIT && succ_reg == $past(succ_reg))
        else $error("missed fit not reported");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_pass |=> t_reg <= LAST_STEP)
        else $error("pass step counter out of range");

endmodule

`default_nettype wire

[hw/rtl/safp_cell.sv]
// One table slot: a segment entry with its neighbour hand-off logic.
`default_nettype none

module safp_cell #(
    parameter int IDX    = 0,
    parameter int SIZE_W = safp_pkg::SIZE_BITS,
    parameter int OWN_W  = safp_pkg::OWNER_BITS,
    parameter int IDX_W  = 6,
    parameter logic [SIZE_W-1:0] RST_SIZE = '0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire safp_pkg::safp_ctrl_t ctrl,
    input  wire logic [IDX_W-1:0]    p,
    input  wire logic                w_used,
    input  wire logic [SIZE_W-1:0]   w_size,
    input  wire logic [OWN_W-1:0]    w_owner,
    input  wire logic [SIZE_W-1:0]   r_size,
    input  wire logic                l_v,
    input  wire logic                l_u,
    input  wire logic [SIZE_W-1:0]   l_sz,
    input  wire logic [OWN_W-1:0]    l_ow,
    input  wire logic                r_v,
    input  wire logic                r_u,
    input  wire logic [SIZE_W-1:0]   r_sz,
    input  wire logic [OWN_W-1:0]    r_ow,
    input  wire logic                hole_in,
    output logic                     v,
    output logic                     u,
    output logic [SIZE_W-1:0]        sz,
    output logic [OWN_W-1:0]         ow,
    output logic                     hole_out,
    output logic                     gap
);

    localparam logic [IDX_W:0] ME = (IDX_W+1)'(IDX);

    logic              v_reg, v_next;
    logic              u_reg, u_next;
    logic [SIZE_W-1:0] sz_reg, sz_next;
    logic [OWN_W-1:0]  ow_reg, ow_next;
    logic [IDX_W:0]    p_ext, p_one;

    assign p_ext = {1'b0, p};
    assign p_one = p_ext + (IDX_W+1)'(1);

    // A hole here or anywhere to the left pulls the right neighbour in
    assign hole_out = hole_in | ~v_reg;
    assign gap      = v_reg & hole_in;

    // Next entry
    always_comb
    begin
        v_next  = v_reg;
        u_next  = u_reg;
        sz_next = sz_reg;
        ow_next = ow_reg;
        unique case (ctrl.op)
            safp_pkg::OP_HOLD:
            begin
            end
            safp_pkg::OP_ROTATE:
            begin
                v_next  = l_v;
                u_next  = l_u;
                sz_next = l_sz;
                ow_next = l_ow;
            end
            safp_pkg::OP_SQUEEZE:
            begin
                if (hole_out)
                begin
                    v_next  = r_v;
                    u_next  = r_u;
                    sz_next = r_sz;
                    ow_next = r_ow;
                end
            end
            safp_pkg::OP_INSERT:
            begin
                priority if (ME == p_ext)
                begin
                    v_next  = 1'b1;
                    u_next  = w_used;
                    sz_next = w_size;
                    ow_next = w_owner;
                end
                else if (ctrl.split && ME == p_one)
                begin
                    v_next  = 1'b1;
                    u_next  = 1'b0;
                    sz_next = r_size;
                end
                else if (ctrl.split && ME > p_one)
                begin
                    v_next  = l_v;
                    u_next  = l_u;
                    sz_next = l_sz;
                    ow_next = l_ow;
                end
                else
                begin
                end
            end
            safp_pkg::OP_WRITE:
            begin
                if (ME == p_ext)
                begin
                    v_next  = 1'b1;
                    u_next  = w_used;
                    sz_next = w_size;
                    ow_next = w_owner;
                end
            end
            safp_pkg::OP_INIT:
            begin
                if (ME == '0)
                begin
                    v_next  = 1'b1;
                    u_next  = w_used;
                    sz_next = w_size;
                    ow_next = w_owner;
                end
                else
                begin
                    v_next = 1'b0;
                    u_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and size state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= (IDX == 0);
            u_reg  <= 1'b0;
            sz_reg <= (IDX == 0) ? RST_SIZE : '0;
        end
        else
        begin
            v_reg  <= v_next;
            u_reg  <= u_next;
            sz_reg <= sz_next;
        end
    end

    // Owner is only read for used entries
    always_ff @(posedge clk)
    begin
        ow_reg <= ow_next;
    end

    assign v  = v_reg;
    assign u  = u_reg;
    assign sz = sz_reg;
    assign ow = ow_reg;

endmodule

`default_nettype wire

[hw/rtl/safp_chain.sv]
// Row of segment cells wired as a ring through the controller.
`default_nettype none

module safp_chain #(
    parameter int MAX_SEGMENTS = safp_pkg::MAX_SEGMENTS,
    parameter int SIZE_W       = safp_pkg::SIZE_BITS,
    parameter int OWN_W        = safp_pkg::OWNER_BITS,
    parameter int IDX_W        = $clog2(MAX_SEGMENTS),
    parameter logic [SIZE_W-1:0] RST_SIZE = '0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire safp_pkg::safp_ctrl_t ctrl,
    input  wire logic [IDX_W-1:0]     p,
    input  wire logic                 w_used,
    input  wire logic [SIZE_W-1:0]    w_size,
    input  wire logic [OWN_W-1:0]     w_owner,
    input  wire logic [SIZE_W-1:0]    r_size,
    input  wire logic                 head_v,
    input  wire logic                 head_u,
    input  wire logic [SIZE_W-1:0]    head_sz,
    input  wire logic [OWN_W-1:0]     head_ow,
    output logic                      tail_v,
    output logic                      tail_u,
    output logic [SIZE_W-1:0]         tail_sz,
    output logic [OWN_W-1:0]          tail_ow,
    output logic                      need_squeeze
);

    logic [MAX_SEGMENTS-1:0] v_vec, u_vec, hole_vec, gap_vec;
    logic [SIZE_W-1:0]       sz_a [MAX_SEGMENTS];
    logic [OWN_W-1:0]        ow_a [MAX_SEGMENTS];

    // Cells: left neighbour feeds rotation, right neighbour feeds squeeze
    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        logic              lv, lu, rv, ru, hin;
        logic [SIZE_W-1:0] lsz, rsz;
        logic [OWN_W-1:0]  lo, ro;

        if (i == 0)
        begin : g_first
            assign lv  = head_v;
            assign lu  = head_u;
            assign lsz = head_sz;
            assign lo  = head_ow;
            assign hin = 1'b0;
        end
        else
        begin : g_mid
            assign lv  = v_vec[i-1];
            assign lu  = u_vec[i-1];
            assign lsz = sz_a[i-1];
            assign lo  = ow_a[i-1];
            assign hin = hole_vec[i-1];
        end

        if (i == MAX_SEGMENTS - 1)
        begin : g_last
            assign rv  = 1'b0;
            assign ru  = 1'b0;
            assign rsz = '0;
            assign ro  = '0;
        end
        else
        begin : g_inner
            assign rv  = v_vec[i+1];
            assign ru  = u_vec[i+1];
            assign rsz = sz_a[i+1];
            assign ro  = ow_a[i+1];
        end

        safp_cell #(
            .IDX      (i),
            .SIZE_W   (SIZE_W),
            .OWN_W    (OWN_W),
            .IDX_W    (IDX_W),
            .RST_SIZE (RST_SIZE)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .p        (p),
            .w_used   (w_used),
            .w_size   (w_size),
            .w_owner  (w_owner),
            .r_size   (r_size),
            .l_v      (lv),
            .l_u      (lu),
            .l_sz     (lsz),
            .l_ow     (lo),
            .r_v      (rv),
            .r_u      (ru),
            .r_sz     (rsz),
            .r_ow     (ro),
            .hole_in  (hin),
            .v        (v_vec[i]),
            .u        (u_vec[i]),
            .sz       (sz_a[i]),
            .ow       (ow_a[i]),
            .hole_out (hole_vec[i]),
            .gap      (gap_vec[i])
        );
    end

    // Tail view for the controller
    assign tail_v       = v_vec[MAX_SEGMENTS-1];
    assign tail_u       = u_vec[MAX_SEGMENTS-1];
    assign tail_sz      = sz_a[MAX_SEGMENTS-1];
    assign tail_ow      = ow_a[MAX_SEGMENTS-1];
    assign need_squeeze = |gap_vec;

endmodule

`default_nettype wire

[tb/sv/segment_allocator_fit_policy_tb.sv]
// Testbench for the segment allocator: predicted request results checked item by item.
`timescale 1ns / 1ps

module segment_allocator_fit_policy_tb;

    localparam int NSEG      = safp_pkg::MAX_SEGMENTS;
    localparam int WATCH_MAX = 20000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    safp_pkg::safp_req_t req = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    safp_pkg::safp_rsp_t rsp;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [safp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [safp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    segment_allocator_fit_policy dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Predicted allocator state
    logic [23:0] tbl_size [NSEG];
    logic [15:0] tbl_owner [NSEG];
    logic        tbl_used [NSEG];
    int          tbl_count;
    logic [1:0]  pol;
    logic [23:0] mem_total;
    logic [31:0] grants;

    safp_pkg::safp_rsp_t pending_rsp [$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_rsp = 1'b0;
    int        quiet = 0;

    task automatic table_rebuild();
        for (int i = 0; i < NSEG; i++)
        begin
            tbl_size[i] = '0;
            tbl_owner[i] = '0;
            tbl_used[i] = 1'b0;
        end
        tbl_size[0] = mem_total;
        tbl_count = 1;
    endtask

    function automatic logic [1:0] grant_segment(logic [15:0] who, logic [23:0] want);
        int          at;
        logic [23:0] best;
        at = -1;
        best = '0;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_used[i] || tbl_size[i] < want)
                continue;
            if (pol == safp_pkg::POL_FIRST)
            begin
                at = i;
                break;
            end
            else if (pol == safp_pkg::POL_BEST)
            begin
                if (at < 0 || tbl_size[i] - want < best)
                begin
                    best = tbl_size[i] - want;
                    at = i;
                end
            end
            else if (pol == safp_pkg::POL_WORST)
            begin
                if (tbl_size[i] > best)
                begin
                    best = tbl_size[i];
                    at = i;
                end
            end
        end
        if (at < 0)
            return safp_pkg::STAT_NOFIT;
        if (tbl_size[at] > want)
        begin
            if (tbl_count >= NSEG)
                return safp_pkg::STAT_FULL;
            for (int j = tbl_count; j > at + 1; j--)
            begin
                tbl_size[j] = tbl_size[j-1];
                tbl_owner[j] = tbl_owner[j-1];
                tbl_used[j] = tbl_used[j-1];
            end
            tbl_size[at+1] = tbl_size[at] - want;
            tbl_owner[at+1] = '0;
            tbl_used[at+1] = 1'b0;
            tbl_count++;
        end
        tbl_size[at] = want;
        tbl_owner[at] = who;
        tbl_used[at] = 1'b1;
        if (grants != 32'hFFFF_FFFF)
            grants++;
        return safp_pkg::STAT_DONE;
    endfunction

    task automatic release_owner(logic [15:0] who);
        int w;
        w = 0;
        for (int r = 0; r < tbl_count; r++)
            if (tbl_used[r] && tbl_owner[r] == who)
            begin
                tbl_used[r] = 1'b0;
                tbl_owner[r] = '0;
            end
        for (int r = 0; r < tbl_count; r++)
        begin
            if (w > 0 && !tbl_used[r] && !tbl_used[w-1])
            begin
                tbl_size[w-1] = tbl_size[w-1] + tbl_size[r];
                continue;
            end
            tbl_size[w] = tbl_size[r];
            tbl_owner[w] = tbl_owner[r];
            tbl_used[w] = tbl_used[r];
            w++;
        end
        tbl_count = w;
    endtask

    task automatic pack_table();
        int          w;
        logic [23:0] spare;
        w = 0;
        spare = '0;
        for (int r = 0; r < tbl_count; r++)
        begin
            if (!tbl_used[r])
            begin
                spare = spare + tbl_size[r];
                continue;
            end
            tbl_size[w] = tbl_size[r];
            tbl_owner[w] = tbl_owner[r];
            tbl_used[w] = 1'b1;
            w++;
        end
        if (w == 0)
        begin
            tbl_size[0] = (spare != 0) ? spare : mem_total;
            tbl_owner[0] = '0;
            tbl_used[0] = 1'b0;
            w = 1;
        end
        else if (spare != 0)
        begin
            tbl_size[w] = spare;
            tbl_owner[w] = '0;
            tbl_used[w] = 1'b0;
            w++;
        end
        tbl_count = w;
    endtask

    // Apply one request to the predicted table and queue its result
    task automatic predict_request(safp_pkg::safp_req_t r);
        safp_pkg::safp_rsp_t e;
        logic [25:0]         used, spare;
        e = '0;
        used = '0;
        spare = '0;
        if (r.req_type == safp_pkg::REQ_ALLOC)
            e.status = grant_segment(r.owner_id, r.req_size);
        else if (r.req_type == safp_pkg::REQ_FREE)
            release_owner(r.owner_id);
        else if (r.req_type == safp_pkg::REQ_COMPACT)
            pack_table();
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_used[i])
                used += tbl_size[i];
            else
            begin
                spare += tbl_size[i];
                if (tbl_size[i] > e.largest_free)
                    e.largest_free = tbl_size[i];
            end
        end
        e.used_total = used[23:0];
        e.free_total = spare[23:0];
        e.alloc_count = grants;
        e.segments_in_use = 7'(tbl_count);
        pending_rsp.push_back(e);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        safp_pkg::safp_rsp_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected item", 32'd1, 32'd0);
            else
            begin
                e = pending_rsp.pop_front();
                if (rsp.status !== e.status)
                    report_mismatch("status", rsp.status, e.status);
                if (rsp.used_total !== e.used_total)
                    report_mismatch("used_total", rsp.used_total, e.used_total);
                if (rsp.free_total !== e.free_total)
                    report_mismatch("free_total", rsp.free_total, e.free_total);
                if (rsp.largest_free !== e.largest_free)
                    report_mismatch("largest_free", rsp.largest_free, e.largest_free);
                if (rsp.alloc_count !== e.alloc_count)
                    report_mismatch("alloc_count", rsp.alloc_count, e.alloc_count);
                if (rsp.segments_in_use !== e.segments_in_use)
                    report_mismatch("segments_in_use", rsp.segments_in_use,
                                    e.segments_in_use);
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: cycles with nothing accepted
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCH_MAX)
        begin
            $display("segment_allocator_fit_policy_tb failed");
            $finish;
        end
    end

    // Valid stays up after acceptance; a drain, or an idle draw in the next call, lowers it
    task automatic send_item(logic [1:0] kind, logic [15:0] who, logic [23:0] sz);
        safp_pkg::safp_req_t r;
        r.req_type = kind;
        r.owner_id = who;
        r.req_size = sz;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        predict_request(r);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (3 * NSEG + 10) @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_reg(logic [safp_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == safp_pkg::CFG_POLICY)
            pol = val[1:0];
        else
        begin
            mem_total = val;
            table_rebuild();
        end
    endtask

    task automatic test_directed();
        send_item(safp_pkg::REQ_ALLOC, 16'hFFFF, 24'hFFFFFF);    // exact fit of whole space
        send_item(safp_pkg::REQ_ALLOC, 16'h0001, 24'd0);         // nothing left fits
        send_item(safp_pkg::REQ_FREE, 16'hFFFF, 24'd0);
        send_item(safp_pkg::REQ_ALLOC, 16'h0000, 24'd0);         // zero size alloc
        send_item(safp_pkg::REQ_IGNORED, 16'h1234, 24'd5);       // ignored kind
        send_item(safp_pkg::REQ_FREE, 16'h7777, 24'd0);          // unknown owner
        send_item(safp_pkg::REQ_FREE, 16'h0000, 24'd0);
        write_reg(safp_pkg::CFG_TOTAL, 24'd1000);
        for (int i = 0; i < 6; i++)
            send_item(safp_pkg::REQ_ALLOC, 16'(i), 24'(50 + 20 * i));
        send_item(safp_pkg::REQ_FREE, 16'd1, 24'd0);
        send_item(safp_pkg::REQ_FREE, 16'd3, 24'd0);
        write_reg(safp_pkg::CFG_POLICY, 24'(safp_pkg::POL_BEST));
        send_item(safp_pkg::REQ_ALLOC, 16'd9, 24'd60);           // best fit picks the tightest hole
        write_reg(safp_pkg::CFG_POLICY, 24'(safp_pkg::POL_WORST));
        send_item(safp_pkg::REQ_ALLOC, 16'd10, 24'd10);
        send_item(safp_pkg::REQ_COMPACT, 16'd0, 24'd0);
        write_reg(safp_pkg::CFG_POLICY, 24'(safp_pkg::POL_NONE)); // no policy ever chooses
        send_item(safp_pkg::REQ_ALLOC, 16'd11, 24'd1);
        write_reg(safp_pkg::CFG_TOTAL, 24'd0);
        send_item(safp_pkg::REQ_COMPACT, 16'd0, 24'd0);          // empty table compact
        write_reg(safp_pkg::CFG_POLICY, 24'(safp_pkg::POL_WORST));
        send_item(safp_pkg::REQ_ALLOC, 16'd2, 24'd0);            // worst fit skips zero size
    endtask

    // Fill the table with small grants until it reports full, then free one owner and compact
    task automatic test_table_full();
        write_reg(safp_pkg::CFG_POLICY, 24'(safp_pkg::POL_FIRST));
        write_reg(safp_pkg::CFG_TOTAL, 24'd5000);
        for (int i = 0; i < NSEG + 2; i++)
            send_item(safp_pkg::REQ_ALLOC, 16'($urandom_range(7)),
                      24'($urandom_range(1, 40)));
        send_item(safp_pkg::REQ_FREE, 16'd2, 24'd0);
        send_item(safp_pkg::REQ_COMPACT, 16'd0, 24'd0);
    endtask

    task automatic test_random(int n);
        logic [1:0]  kind;
        logic [23:0] sz;
        int          pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            kind = (pick < 60) ? safp_pkg::REQ_ALLOC : (pick < 85) ? safp_pkg::REQ_FREE :
                   (pick < 97) ? safp_pkg::REQ_COMPACT : safp_pkg::REQ_IGNORED;
            sz = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(300));
            send_item(kind, ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(15)),
                      sz);
        end
    endtask

    // Long receiver stall while items keep coming, then a full pause
    task automatic test_backpressure();
        fork
            begin
                hold_rsp = 1'b1;
                repeat (800) @(posedge clk);
                hold_rsp = 1'b0;
            end
            test_random(8);
        join
        drain_results();
    endtask

    initial
    begin
        pol = safp_pkg::POL_FIRST;
        mem_total = safp_pkg::TOTAL_RESET;
        grants = '0;
        table_rebuild();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        write_reg(safp_pkg::CFG_TOTAL, 24'd4000);
        write_reg(safp_pkg::CFG_POLICY, 24'(safp_pkg::POL_FIRST));
        send_idle_pct = 16;
        recv_idle_pct = 51;
        test_random(170);
        test_backpressure();
        write_reg(safp_pkg::CFG_POLICY, 24'(safp_pkg::POL_BEST));
        write_reg(safp_pkg::CFG_TOTAL, 24'hFFFFFF);
        send_idle_pct = 51;
        recv_idle_pct = 16;
        test_random(170);
        write_reg(safp_pkg::CFG_POLICY, 24'(safp_pkg::POL_WORST));
        write_reg(safp_pkg::CFG_TOTAL, 24'd2500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(150);

        drain_results();
        if (errors == 0)
            $display("segment_allocator_fit_policy_tb passed");
        else
            $display("segment_allocator_fit_policy_tb failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/safp_pkg.sv
hw/rtl/safp_cell.sv
hw/rtl/safp_chain.sv
hw/rtl/segment_allocator_fit_policy.sv
tb/sv/segment_allocator_fit_policy_tb.sv
